FILE: sv/hwpm_pkg.sv
// Shared types and constants of the host wake and ping monitor.
// Used by hwpm_ctrl, hwpm_dp and host_wake_ping_monitor; depends on nothing.
`timescale 1ns / 1ps

package hwpm_pkg;

   localparam int HOST_W        = 3;
   localparam int SEQ_W         = 16;
   localparam int TIME_W        = 32;
   localparam int CNT_W         = 8;
   localparam int MASK_W        = 8;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int DEF_NUM_HOSTS = 8;

   localparam logic [TIME_W-1:0] RST_PING_TIMEOUT   = 32'd2000;
   localparam logic [TIME_W-1:0] RST_RETRY_INTERVAL = 32'd5000;
   localparam logic [CNT_W-1:0]  RST_PINGS_PER_ATT  = 8'd6;
   localparam logic [CNT_W-1:0]  RST_MAX_ATTEMPTS   = 8'd3;
   localparam logic [TIME_W-1:0] RST_HEALTH_INT     = 32'd300000;
   localparam logic [CNT_W-1:0]  CNT_MAX            = 8'hFF;

   typedef enum logic [1:0] {
      REQ_TICK,
      REQ_REPLY,
      REQ_WAKE_ONE,
      REQ_WAKE_ALL
   } req_kind_type;

   typedef enum logic [1:0] {
      ACT_WAKE,
      ACT_PING,
      ACT_UP,
      ACT_DOWN
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PING_TIMEOUT,
      CSR_RETRY_INTERVAL,
      CSR_PINGS_PER_ATT,
      CSR_MAX_ATTEMPTS,
      CSR_HEALTH_INT,
      CSR_AUTO_WAKE,
      CSR_ACTIVE_MASK,
      CSR_ADDRESSED_MASK
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_TIMEOUT,
      OP_RETRY_STEP,
      OP_HEALTH,
      OP_WAKE,
      OP_PING,
      OP_REPLY,
      OP_FLUSH
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TIMEOUT,
      ST_RETRY,
      ST_HEALTH,
      ST_WAKE,
      ST_PING,
      ST_REPLY,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      op_type             op;
      logic               load;
      logic [HOST_W-1:0]  host;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic addressed;
      logic ping_waiting;
      logic retry_running;
      logic wake_on_down;
      logic timeout_hit;
      logic retry_due;
      logic retry_full;
      logic retry_done;
      logic health_due;
      logic reply_match;
   } status_type;

endpackage

FILE: sv/hwpm_ctrl.sv
// Controller of the host wake and ping monitor: walks the hosts and sequences
// the record operations of one item. Depends on hwpm_pkg.
`timescale 1ns / 1ps

module hwpm_ctrl import hwpm_pkg::*; #(
   parameter int NUM_HOSTS = DEF_NUM_HOSTS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_type,
   input  logic [HOST_W-1:0] req_host_index,
   input  status_type        status,
   output logic              busy,
   output cmd_type           cmd
);

   localparam logic [HOST_W-1:0] LAST_HOST = HOST_W'(NUM_HOSTS - 1);

   state_type         state_ff, state_in;
   req_kind_type      mode_ff, mode_in;
   logic [HOST_W-1:0] host_ff, host_in;
   logic              done_host;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= REQ_TICK;
         host_ff  <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         host_ff  <= host_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      host_in   = host_ff;
      done_host = 1'b0;
      cmd.op    = OP_NONE;
      cmd.load  = 1'b0;
      cmd.host  = host_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               mode_in  = req_kind_type'(req_type);
               unique case (req_kind_type'(req_type))
                  REQ_TICK: begin
                     host_in  = '0;
                     state_in = ST_TIMEOUT;
                  end
                  REQ_WAKE_ALL: begin
                     host_in  = '0;
                     state_in = ST_WAKE;
                  end
                  REQ_REPLY: begin
                     host_in  = req_host_index;
                     state_in = (req_host_index <= LAST_HOST) ? ST_REPLY : ST_FLUSH;
                  end
                  REQ_WAKE_ONE: begin
                     host_in  = req_host_index;
                     state_in = (req_host_index <= LAST_HOST) ? ST_WAKE : ST_FLUSH;
                  end
                  default: state_in = ST_FLUSH;
               endcase
            end
         end
         ST_TIMEOUT: begin
            if (!(status.active && status.addressed)) begin
               done_host = 1'b1;
            end else if (status.timeout_hit) begin
               cmd.op   = OP_TIMEOUT;
               state_in = status.wake_on_down ? ST_WAKE : ST_RETRY;
            end else begin
               state_in = ST_RETRY;
            end
         end
         ST_RETRY: begin
            if (!status.retry_running) begin
               state_in = ST_HEALTH;
            end else if (status.retry_due) begin
               cmd.op = OP_RETRY_STEP;
               if (status.retry_full && status.retry_done) begin
                  done_host = 1'b1;
               end else begin
                  state_in = ST_PING;
               end
            end else begin
               done_host = 1'b1;
            end
         end
         ST_HEALTH: begin
            if (status.health_due) begin
               cmd.op = OP_HEALTH;
               if (status.ping_waiting) begin
                  done_host = 1'b1;
               end else begin
                  state_in = ST_PING;
               end
            end else begin
               done_host = 1'b1;
            end
         end
         ST_WAKE: begin
            if (mode_ff == REQ_WAKE_ALL && !status.active) begin
               done_host = 1'b1;
            end else begin
               cmd.op = OP_WAKE;
               if (status.addressed) begin
                  state_in = ST_PING;
               end else begin
                  done_host = 1'b1;
               end
            end
         end
         ST_PING: begin
            cmd.op    = OP_PING;
            done_host = 1'b1;
         end
         ST_REPLY: begin
            if (status.reply_match) begin
               cmd.op = OP_REPLY;
            end
            state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            cmd.op   = OP_FLUSH;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (done_host) begin
         if (mode_ff == REQ_WAKE_ONE || host_ff == LAST_HOST) begin
            state_in = ST_FLUSH;
         end else begin
            host_in  = host_ff + HOST_W'(1);
            state_in = (mode_ff == REQ_TICK) ? ST_TIMEOUT : ST_WAKE;
         end
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: sv/hwpm_dp.sv
// Datapath of the host wake and ping monitor: configuration registers, host
// records, age compares and the result holding stage. Depends on hwpm_pkg.
`timescale 1ns / 1ps

module hwpm_dp import hwpm_pkg::*; #(
   parameter int NUM_HOSTS = DEF_NUM_HOSTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic [TIME_W-1:0]     req_now_ms,
   input  logic [SEQ_W-1:0]      req_reply_seq,
   input  cmd_type               cmd,
   output status_type            status,
   output logic                  rsp_strobe,
   output logic [1:0]            rsp_action,
   output logic [HOST_W-1:0]     rsp_target_host,
   output logic [SEQ_W-1:0]      rsp_ping_seq,
   output logic                  rsp_last
);

   localparam int IDX_W = (NUM_HOSTS > 1) ? $clog2(NUM_HOSTS) : 1;

   logic [TIME_W-1:0] ping_timeout_ff, retry_interval_ff, health_int_ff;
   logic [CNT_W-1:0]  pings_per_att_ff, max_attempts_ff;
   logic              auto_wake_ff;
   logic [MASK_W-1:0] active_mask_ff, addressed_mask_ff;

   logic              up_ff      [NUM_HOSTS];
   logic              pw_ff      [NUM_HOSTS];
   logic              rr_ff      [NUM_HOSTS];
   logic [CNT_W-1:0]  attempt_ff [NUM_HOSTS];
   logic [CNT_W-1:0]  pings_ff   [NUM_HOSTS];
   logic [SEQ_W-1:0]  exp_seq_ff [NUM_HOSTS];
   logic [TIME_W-1:0] lpt_ff     [NUM_HOSTS];
   logic [TIME_W-1:0] lht_ff     [NUM_HOSTS];
   logic [SEQ_W-1:0]  seq_ff, seq_in;

   logic              up_in, pw_in, rr_in;
   logic [CNT_W-1:0]  attempt_in, pings_in;
   logic [SEQ_W-1:0]  exp_seq_in;
   logic [TIME_W-1:0] lpt_in, lht_in;

   logic [TIME_W-1:0] now_ff;
   logic [SEQ_W-1:0]  rseq_ff;

   logic              pend_valid_ff, pend_valid_in;
   action_type        pend_act_ff;
   logic [HOST_W-1:0] pend_host_ff;
   logic [SEQ_W-1:0]  pend_seq_ff;
   logic              strobe_ff, strobe_in;
   action_type        out_act_ff;
   logic [HOST_W-1:0] out_host_ff;
   logic [SEQ_W-1:0]  out_seq_ff;
   logic              out_last_ff;

   logic [IDX_W-1:0]  idx;
   logic              cur_up, cur_pw, cur_rr;
   logic [CNT_W-1:0]  cur_attempt, cur_pings, pings_inc;
   logic [SEQ_W-1:0]  cur_exp_seq, seq_next;
   logic [TIME_W-1:0] ping_age, health_age;
   logic              emit_en;
   action_type        emit_act;
   logic [SEQ_W-1:0]  emit_seq;

   assign idx         = cmd.host[IDX_W-1:0];
   assign cur_up      = up_ff[idx];
   assign cur_pw      = pw_ff[idx];
   assign cur_rr      = rr_ff[idx];
   assign cur_attempt = attempt_ff[idx];
   assign cur_pings   = pings_ff[idx];
   assign cur_exp_seq = exp_seq_ff[idx];
   assign ping_age    = now_ff - lpt_ff[idx];
   assign health_age  = now_ff - lht_ff[idx];
   assign pings_inc   = (cur_pings == CNT_MAX) ? cur_pings : cur_pings + CNT_W'(1);
   assign seq_next    = seq_ff + SEQ_W'(1);

   always_comb begin
      status.active        = active_mask_ff[cmd.host];
      status.addressed     = addressed_mask_ff[cmd.host];
      status.ping_waiting  = cur_pw;
      status.retry_running = cur_rr;
      status.wake_on_down  = cur_up && !cur_rr && auto_wake_ff;
      status.timeout_hit   = cur_pw && (ping_age >= ping_timeout_ff);
      status.retry_due     = !cur_pw && (ping_age >= retry_interval_ff);
      status.retry_full    = (pings_inc >= pings_per_att_ff);
      status.retry_done    = (cur_attempt >= max_attempts_ff);
      status.health_due    = (health_age >= health_int_ff);
      status.reply_match   = status.active && status.addressed && cur_pw
                             && (cur_exp_seq == rseq_ff);
   end

   always_comb begin
      up_in      = cur_up;
      pw_in      = cur_pw;
      rr_in      = cur_rr;
      attempt_in = cur_attempt;
      pings_in   = cur_pings;
      exp_seq_in = cur_exp_seq;
      lpt_in     = lpt_ff[idx];
      lht_in     = lht_ff[idx];
      seq_in     = seq_ff;
      emit_en    = 1'b0;
      emit_act   = ACT_WAKE;
      emit_seq   = '0;

      unique case (cmd.op)
         OP_TIMEOUT: begin
            pw_in = 1'b0;
            up_in = 1'b0;
            if (cur_up) begin
               emit_en  = 1'b1;
               emit_act = ACT_DOWN;
            end
         end
         OP_RETRY_STEP: begin
            if (status.retry_full) begin
               pings_in = '0;
               if (status.retry_done) begin
                  rr_in      = 1'b0;
                  attempt_in = '0;
               end else begin
                  attempt_in = cur_attempt + CNT_W'(1);
                  emit_en    = 1'b1;
                  emit_act   = ACT_WAKE;
               end
            end else begin
               pings_in = pings_inc;
            end
         end
         OP_HEALTH: lht_in = now_ff;
         OP_WAKE: begin
            emit_en  = 1'b1;
            emit_act = ACT_WAKE;
            if (status.addressed) begin
               rr_in      = 1'b1;
               attempt_in = CNT_W'(1);
               pings_in   = '0;
               up_in      = 1'b0;
            end
         end
         OP_PING: begin
            if (status.addressed) begin
               seq_in     = seq_next;
               emit_en    = 1'b1;
               emit_act   = ACT_PING;
               emit_seq   = seq_next;
               pw_in      = 1'b1;
               exp_seq_in = seq_next;
               lpt_in     = now_ff;
            end
         end
         OP_REPLY: begin
            pw_in = 1'b0;
            up_in = 1'b1;
            if (cur_rr) begin
               rr_in      = 1'b0;
               attempt_in = '0;
               pings_in   = '0;
            end
            if (!cur_up) begin
               emit_en  = 1'b1;
               emit_act = ACT_UP;
            end
         end
         OP_NONE, OP_FLUSH: ;
         default: ;
      endcase
   end

   assign strobe_in     = pend_valid_ff && (emit_en || cmd.op == OP_FLUSH);
   assign pend_valid_in = emit_en || (pend_valid_ff && cmd.op != OP_FLUSH);

   always_ff @(posedge clock) begin
      if (reset) begin
         ping_timeout_ff   <= RST_PING_TIMEOUT;
         retry_interval_ff <= RST_RETRY_INTERVAL;
         pings_per_att_ff  <= RST_PINGS_PER_ATT;
         max_attempts_ff   <= RST_MAX_ATTEMPTS;
         health_int_ff     <= RST_HEALTH_INT;
         auto_wake_ff      <= 1'b0;
         active_mask_ff    <= '0;
         addressed_mask_ff <= '0;
         for (int i = 0; i < NUM_HOSTS; i++) begin
            up_ff[i]      <= 1'b0;
            pw_ff[i]      <= 1'b0;
            rr_ff[i]      <= 1'b0;
            attempt_ff[i] <= '0;
            pings_ff[i]   <= '0;
            exp_seq_ff[i] <= '0;
            lpt_ff[i]     <= '0;
            lht_ff[i]     <= '0;
         end
         seq_ff        <= '0;
         pend_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_PING_TIMEOUT:   ping_timeout_ff   <= csr_write_data[TIME_W-1:0];
               CSR_RETRY_INTERVAL: retry_interval_ff <= csr_write_data[TIME_W-1:0];
               CSR_PINGS_PER_ATT:  pings_per_att_ff  <= csr_write_data[CNT_W-1:0];
               CSR_MAX_ATTEMPTS:   max_attempts_ff   <= csr_write_data[CNT_W-1:0];
               CSR_HEALTH_INT:     health_int_ff     <= csr_write_data[TIME_W-1:0];
               CSR_AUTO_WAKE:      auto_wake_ff      <= csr_write_data[0];
               CSR_ACTIVE_MASK:    active_mask_ff    <= csr_write_data[MASK_W-1:0];
               CSR_ADDRESSED_MASK: addressed_mask_ff <= csr_write_data[MASK_W-1:0];
               default: ;
            endcase
         end
         up_ff[idx]      <= up_in;
         pw_ff[idx]      <= pw_in;
         rr_ff[idx]      <= rr_in;
         attempt_ff[idx] <= attempt_in;
         pings_ff[idx]   <= pings_in;
         exp_seq_ff[idx] <= exp_seq_in;
         lpt_ff[idx]     <= lpt_in;
         lht_ff[idx]     <= lht_in;
         seq_ff          <= seq_in;
         pend_valid_ff   <= pend_valid_in;
         strobe_ff       <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff  <= req_now_ms;
         rseq_ff <= req_reply_seq;
      end
      if (emit_en) begin
         pend_act_ff  <= emit_act;
         pend_host_ff <= cmd.host;
         pend_seq_ff  <= emit_seq;
      end
      if (strobe_in) begin
         out_act_ff  <= pend_act_ff;
         out_host_ff <= pend_host_ff;
         out_seq_ff  <= pend_seq_ff;
         out_last_ff <= (cmd.op == OP_FLUSH);
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_action      = out_act_ff;
   assign rsp_target_host = out_host_ff;
   assign rsp_ping_seq    = out_seq_ff;
   assign rsp_last        = out_last_ff;

endmodule

FILE: sv/host_wake_ping_monitor.sv
// Host wake and ping monitor, top level: joins hwpm_ctrl and hwpm_dp.
// Depends on hwpm_pkg, hwpm_ctrl and hwpm_dp.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low; busy stays high until
// the item is finished. The controller walks the host records one at a time:
// a tick visits every host, a reply and a single wake touch one host, and a
// wake of all hosts visits every host, each item ending with a closing step.
// Each result is held one stage so that its last flag is
// known: it shows on the rsp_ ports for one cycle with rsp_strobe, and the
// final one, with rsp_last set, shows in the cycle in which busy falls.
// Results cannot be held off; an item with no action gives no result.
module host_wake_ping_monitor import hwpm_pkg::*; #(
   parameter int NUM_HOSTS = DEF_NUM_HOSTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_type,
   input  logic [TIME_W-1:0]     req_now_ms,
   input  logic [HOST_W-1:0]     req_host_index,
   input  logic [SEQ_W-1:0]      req_reply_seq,
   output logic                  rsp_strobe,
   output logic [1:0]            rsp_action,
   output logic [HOST_W-1:0]     rsp_target_host,
   output logic [SEQ_W-1:0]      rsp_ping_seq,
   output logic                  rsp_last,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   hwpm_ctrl #(
      .NUM_HOSTS (NUM_HOSTS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_type       (req_type),
      .req_host_index (req_host_index),
      .status         (status),
      .busy           (busy),
      .cmd            (cmd)
   );

   hwpm_dp #(
      .NUM_HOSTS (NUM_HOSTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_now_ms       (req_now_ms),
      .req_reply_seq    (req_reply_seq),
      .cmd              (cmd),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_action       (rsp_action),
      .rsp_target_host  (rsp_target_host),
      .rsp_ping_seq     (rsp_ping_seq),
      .rsp_last         (rsp_last)
   );

`ifndef SYNTHESIS
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item taken but block not busy");

   a_strobe_in_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without an item in work");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> !busy)
      else $error("final result while item still in work");
`endif

endmodule

FILE: tb/tb_host_wake_ping_monitor.sv
// Self-checking testbench for host_wake_ping_monitor: directed and random items
// checked against a built-in predictor of the host liveness table.
// Depends on hwpm_pkg and host_wake_ping_monitor.
`timescale 1ns / 1ps

module tb_host_wake_ping_monitor import hwpm_pkg::*;;

   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      action_type        act;
      logic [HOST_W-1:0] host;
      logic [SEQ_W-1:0]  seq;
      logic              last;
   } host_action_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_type;
   logic [TIME_W-1:0]     req_now_ms;
   logic [HOST_W-1:0]     req_host_index;
   logic [SEQ_W-1:0]      req_reply_seq;
   logic                  rsp_strobe;
   logic [1:0]            rsp_action;
   logic [HOST_W-1:0]     rsp_target_host;
   logic [SEQ_W-1:0]      rsp_ping_seq;
   logic                  rsp_last;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   // predicted configuration
   logic [TIME_W-1:0] cfg_timeout, cfg_retry_gap, cfg_health;
   logic [CNT_W-1:0]  cfg_pings_per, cfg_max_att;
   logic [MASK_W-1:0] cfg_active, cfg_addressed;
   logic              cfg_auto;

   // predicted liveness table
   logic              host_is_up [DEF_NUM_HOSTS];
   logic              ping_out   [DEF_NUM_HOSTS];
   logic              retry_on   [DEF_NUM_HOSTS];
   logic [CNT_W-1:0]  attempts   [DEF_NUM_HOSTS];
   logic [CNT_W-1:0]  att_pings  [DEF_NUM_HOSTS];
   logic [SEQ_W-1:0]  want_seq   [DEF_NUM_HOSTS];
   logic [TIME_W-1:0] ping_stamp [DEF_NUM_HOSTS];
   logic [TIME_W-1:0] health_stamp [DEF_NUM_HOSTS];
   logic [SEQ_W-1:0]  seq_count;

   host_action_type item_actions[$];
   host_action_type pending_actions[$];
   int           fail_count;
   int           calm_left;
   logic [TIME_W-1:0] wall_ms;

   host_wake_ping_monitor uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_now_ms       (req_now_ms),
      .req_host_index   (req_host_index),
      .req_reply_seq    (req_reply_seq),
      .rsp_strobe       (rsp_strobe),
      .rsp_action       (rsp_action),
      .rsp_target_host  (rsp_target_host),
      .rsp_ping_seq     (rsp_ping_seq),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   task automatic note_action(action_type a, int h, logic [SEQ_W-1:0] s);
      host_action_type r;
      r.act  = a;
      r.host = h[HOST_W-1:0];
      r.seq  = s;
      r.last = 1'b0;
      item_actions.push_back(r);
   endtask

   task automatic predict_ping(int h, logic [TIME_W-1:0] now);
      if (cfg_addressed[h]) begin
         seq_count = seq_count + 16'd1;
         note_action(ACT_PING, h, seq_count);
         ping_out[h]   = 1'b1;
         want_seq[h]   = seq_count;
         ping_stamp[h] = now;
      end
   endtask

   task automatic predict_wake(int h, logic [TIME_W-1:0] now);
      note_action(ACT_WAKE, h, '0);
      if (cfg_addressed[h]) begin
         retry_on[h]   = 1'b1;
         attempts[h]   = 8'd1;
         att_pings[h]  = 8'd0;
         host_is_up[h] = 1'b0;
         predict_ping(h, now);
      end
   endtask

   task automatic predict_tick_host(int h, logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] age;
      logic              was_up;
      if (cfg_active[h] && cfg_addressed[h]) begin
         age = now - ping_stamp[h];
         if (ping_out[h] && age >= cfg_timeout) begin
            was_up        = host_is_up[h];
            ping_out[h]   = 1'b0;
            host_is_up[h] = 1'b0;
            if (was_up) note_action(ACT_DOWN, h, '0);
            if (was_up && !retry_on[h] && cfg_auto) predict_wake(h, now);
         end
         if (retry_on[h]) begin
            age = now - ping_stamp[h];
            if (!ping_out[h] && age >= cfg_retry_gap) begin
               if (att_pings[h] != CNT_MAX) att_pings[h] = att_pings[h] + 8'd1;
               if (att_pings[h] >= cfg_pings_per) begin
                  if (attempts[h] >= cfg_max_att) begin
                     retry_on[h]  = 1'b0;
                     attempts[h]  = 8'd0;
                     att_pings[h] = 8'd0;
                  end else begin
                     attempts[h]  = attempts[h] + 8'd1;
                     att_pings[h] = 8'd0;
                     note_action(ACT_WAKE, h, '0);
                     predict_ping(h, now);
                  end
               end else begin
                  predict_ping(h, now);
               end
            end
         end else begin
            age = now - health_stamp[h];
            if (age >= cfg_health) begin
               health_stamp[h] = now;
               if (!ping_out[h]) predict_ping(h, now);
            end
         end
      end
   endtask

   task automatic predict_host_actions(req_kind_type kind, logic [TIME_W-1:0] now,
                                       logic [HOST_W-1:0] host, logic [SEQ_W-1:0] seq);
      host_action_type tail;
      logic            prior_down;
      int              h;
      h = int'(host);
      case (kind)
         REQ_TICK: begin
            for (int i = 0; i < DEF_NUM_HOSTS; i++) predict_tick_host(i, now);
         end
         REQ_REPLY: begin
            if (cfg_active[h] && cfg_addressed[h] && ping_out[h] && want_seq[h] == seq) begin
               prior_down    = !host_is_up[h];
               ping_out[h]   = 1'b0;
               host_is_up[h] = 1'b1;
               if (retry_on[h]) begin
                  retry_on[h]  = 1'b0;
                  attempts[h]  = 8'd0;
                  att_pings[h] = 8'd0;
               end
               if (prior_down) note_action(ACT_UP, h, '0);
            end
         end
         REQ_WAKE_ONE: begin
            predict_wake(h, now);
         end
         default: begin
            for (int i = 0; i < DEF_NUM_HOSTS; i++)
               if (cfg_active[i]) predict_wake(i, now);
         end
      endcase
      if (item_actions.size() > 0) begin
         tail = item_actions.pop_back();
         tail.last = 1'b1;
         item_actions.push_back(tail);
      end
      while (item_actions.size() > 0) pending_actions.push_back(item_actions.pop_front());
   endtask

   task automatic send_item(req_kind_type kind, logic [TIME_W-1:0] now,
                            logic [HOST_W-1:0] host, logic [SEQ_W-1:0] seq);
      int unsigned gap;
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(4, 16);
         gap = $urandom_range(0, 16);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_type       <= kind;
      req_now_ms     <= now;
      req_host_index <= host;
      req_reply_seq  <= seq;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      predict_host_actions(kind, now, host, seq);
      @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_PING_TIMEOUT:   cfg_timeout   = value;
         CSR_RETRY_INTERVAL: cfg_retry_gap = value;
         CSR_PINGS_PER_ATT:  cfg_pings_per = value[CNT_W-1:0];
         CSR_MAX_ATTEMPTS:   cfg_max_att   = value[CNT_W-1:0];
         CSR_HEALTH_INT:     cfg_health    = value;
         CSR_AUTO_WAKE:      cfg_auto      = value[0];
         CSR_ACTIVE_MASK:    cfg_active    = value[MASK_W-1:0];
         default:            cfg_addressed = value[MASK_W-1:0];
      endcase
   endtask

   task automatic set_timing(logic [31:0] timeout, logic [31:0] retry_gap, logic [7:0] pings,
                             logic [7:0] max_att, logic [31:0] health);
      write_reg(CSR_PING_TIMEOUT, timeout);
      write_reg(CSR_RETRY_INTERVAL, retry_gap);
      write_reg(CSR_PINGS_PER_ATT, {24'd0, pings});
      write_reg(CSR_MAX_ATTEMPTS, {24'd0, max_att});
      write_reg(CSR_HEALTH_INT, health);
   endtask

   task automatic set_hosts(logic auto_on, logic [7:0] active, logic [7:0] addressed);
      write_reg(CSR_AUTO_WAKE, {31'd0, auto_on});
      write_reg(CSR_ACTIVE_MASK, {24'd0, active});
      write_reg(CSR_ADDRESSED_MASK, {24'd0, addressed});
   endtask

   // hold the sender until every result is in, then let the block go idle
   task automatic drain_and_settle();
      start <= 1'b0;
      while (pending_actions.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_traffic(int count, int unsigned step_max);
      int unsigned       roll;
      int                tries;
      req_kind_type      kind;
      logic [HOST_W-1:0] host;
      logic [SEQ_W-1:0]  seq;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         host = HOST_W'($urandom_range(0, 7));
         seq  = SEQ_W'($urandom());
         if ($urandom_range(0, 24) == 0) wall_ms = $urandom();
         else wall_ms = wall_ms + $urandom_range(0, step_max);
         if (roll < 50) begin
            kind = REQ_TICK;
         end else if (roll < 75) begin
            kind = REQ_REPLY;
            if (roll < 70) begin
               tries = 0;
               while (tries < DEF_NUM_HOSTS &&
                      !(ping_out[host] && cfg_active[host] && cfg_addressed[host])) begin
                  host = host + 3'd1;
                  tries++;
               end
               seq = want_seq[host];
            end
         end else if (roll < 90) begin
            kind = REQ_WAKE_ONE;
         end else begin
            kind = REQ_WAKE_ALL;
         end
         send_item(kind, wall_ms, host, seq);
      end
   endtask

   task automatic test_idle_after_reset();
      send_item(REQ_TICK, 32'd0, 3'd0, 16'd0);
      send_item(REQ_WAKE_ONE, 32'd1, 3'd7, 16'd0);
      send_item(REQ_WAKE_ALL, 32'd2, 3'd0, 16'd0);
      send_item(REQ_REPLY, 32'd3, 3'd0, 16'd0);
      send_item(REQ_TICK, 32'hFFFF_FFFF, 3'd5, 16'hFFFF);
      drain_and_settle();
   endtask

   task automatic test_wake_and_verify();
      set_timing(32'd10, 32'd20, 8'd2, 8'd2, 32'd50);
      set_hosts(1'b1, 8'b1111_0111, 8'b0111_1110);
      send_item(REQ_WAKE_ALL, 32'hFFFF_FFF0, 3'd0, 16'd0);
      send_item(REQ_REPLY, 32'hFFFF_FFF2, 3'd1, want_seq[1]);
      send_item(REQ_REPLY, 32'hFFFF_FFF3, 3'd2, ~want_seq[2]);
      send_item(REQ_REPLY, 32'hFFFF_FFF4, 3'd1, want_seq[1]);
      send_item(REQ_TICK, 32'd5, 3'd0, 16'd0);
      send_item(REQ_TICK, 32'd30, 3'd0, 16'd0);
      send_item(REQ_TICK, 32'd60, 3'd0, 16'd0);
      send_item(REQ_REPLY, 32'd61, 3'd1, want_seq[1]);
      send_item(REQ_TICK, 32'd200, 3'd0, 16'd0);
      send_item(REQ_TICK, 32'd300, 3'd0, 16'd0);
      send_item(REQ_WAKE_ONE, 32'd310, 3'd3, 16'd0);
      send_item(REQ_REPLY, 32'd311, 3'd3, want_seq[3]);
      drain_and_settle();
   endtask

   task automatic test_zero_pings_per_attempt();
      set_timing(32'd10, 32'd20, 8'd0, 8'd2, 32'd50);
      send_item(REQ_WAKE_ONE, 32'd400, 3'd4, 16'd0);
      send_item(REQ_TICK, 32'd500, 3'd0, 16'd0);
      send_item(REQ_TICK, 32'd600, 3'd0, 16'd0);
      send_item(REQ_TICK, 32'd700, 3'd0, 16'd0);
      drain_and_settle();
      wall_ms = 32'd700;
   endtask

   task automatic test_random_short_intervals();
      set_timing($urandom_range(1, 40), $urandom_range(1, 60), 8'($urandom_range(0, 4)),
                 8'($urandom_range(0, 4)), $urandom_range(1, 100));
      set_hosts(1'($urandom_range(0, 1)), 8'($urandom | 32'h81), 8'($urandom | 32'h18));
      run_traffic(50, 80);
      drain_and_settle();
   endtask

   task automatic test_random_extremes();
      set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      set_hosts(1'b1, 8'hFF, 8'hFF);
      run_traffic(40, 1000);
      drain_and_settle();
      set_timing(32'd1, 32'd1, 8'd1, 8'd1, 32'd1);
      set_hosts(1'b1, 8'hFF, 8'hFF);
      run_traffic(45, 5);
      drain_and_settle();
      set_timing(32'd0, 32'd0, 8'd0, 8'd0, 32'd0);
      set_hosts(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
      run_traffic(40, 3);
      drain_and_settle();
   endtask

   task automatic test_random_moderate();
      set_timing($urandom_range(50, 500), $urandom_range(100, 1000), 8'($urandom_range(1, 8)),
                 8'($urandom_range(1, 6)), $urandom_range(200, 2000));
      set_hosts(1'($urandom_range(0, 1)), 8'($urandom | $urandom), 8'($urandom | $urandom));
      run_traffic(60, 400);
      drain_and_settle();
   endtask

   always @(posedge clock) begin : check_results
      host_action_type want;
      if (!reset && rsp_strobe) begin
         if (pending_actions.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result: expected none, actual action %0d host %0d",
                     $time, rsp_action, rsp_target_host);
         end else begin
            want = pending_actions.pop_front();
            if (rsp_action !== want.act || rsp_target_host !== want.host ||
                rsp_ping_seq !== want.seq || rsp_last !== want.last) begin
               fail_count++;
               $display("%0t: mismatch: expected act %0d host %0d seq %0d last %0d, %s",
                        $time, want.act, want.host, want.seq, want.last,
                        $sformatf("actual act %0d host %0d seq %0d last %0d", rsp_action,
                                  rsp_target_host, rsp_ping_seq, rsp_last));
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_type         = REQ_TICK;
      req_now_ms       = '0;
      req_host_index   = '0;
      req_reply_seq    = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_PING_TIMEOUT;
      csr_write_data   = '0;
      cfg_timeout      = RST_PING_TIMEOUT;
      cfg_retry_gap    = RST_RETRY_INTERVAL;
      cfg_pings_per    = RST_PINGS_PER_ATT;
      cfg_max_att      = RST_MAX_ATTEMPTS;
      cfg_health       = RST_HEALTH_INT;
      cfg_auto         = 1'b0;
      cfg_active       = '0;
      cfg_addressed    = '0;
      for (int i = 0; i < DEF_NUM_HOSTS; i++) begin
         host_is_up[i]   = 1'b0;
         ping_out[i]     = 1'b0;
         retry_on[i]     = 1'b0;
         attempts[i]     = '0;
         att_pings[i]    = '0;
         want_seq[i]     = '0;
         ping_stamp[i]   = '0;
         health_stamp[i] = '0;
      end
      seq_count  = '0;
      fail_count = 0;
      calm_left  = 0;
      wall_ms    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_after_reset();
      test_wake_and_verify();
      test_zero_pings_per_attempt();
      test_random_short_intervals();
      test_random_extremes();
      test_random_moderate();

      if (pending_actions.size() != 0) begin
         fail_count++;
         $display("%0t: results missing: expected %0d more, actual 0",
                  $time, pending_actions.size());
      end
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
